### rtl/fifo_queue_with_remove_by_value_macros.svh
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value_macros.svh
// assertion macros used by the checker file of the queue block
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_VALUE_MACROS_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_VALUE_MACROS_SVH

// property checked while out of reset
`define FQRV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define FQRV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fqrv_pkg.sv
// ----------------------------------------------------------------------------
// fqrv_pkg
// widths, command and status codes, and the result record of the queue block
// ----------------------------------------------------------------------------
package fqrv_pkg;

  // fixed channel field widths
  localparam int CMD_W  = 2;
  localparam int VAL_W  = 10;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SIZE    = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // one result record
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  result_value;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic    idle;
    logic    done;
    result_t res;
  } seq_status_t;

endpackage

### rtl/fqrv_in_if.sv
// ----------------------------------------------------------------------------
// fqrv_in_if
// command channel: valid/ready with command and value
// ----------------------------------------------------------------------------
interface fqrv_in_if;
  logic                        valid;
  logic                        ready;
  logic [fqrv_pkg::CMD_W-1:0]  command;
  logic [fqrv_pkg::VAL_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

### rtl/fqrv_out_if.sv
// ----------------------------------------------------------------------------
// fqrv_out_if
// result channel: valid/ready with status, returned handle and occupancy
// ----------------------------------------------------------------------------
interface fqrv_out_if;
  logic                        valid;
  logic                        ready;
  logic [fqrv_pkg::STAT_W-1:0] status;
  logic [fqrv_pkg::VAL_W-1:0]  result_value;
  logic [fqrv_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output result_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input result_value, input occupancy,
                  output ready);
endinterface

### rtl/fqrv_store.sv
// ----------------------------------------------------------------------------
// fqrv_store
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fqrv_store #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VALUE_BITS-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VALUE_BITS-1:0]    rdata
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/fqrv_seq.sv
// ----------------------------------------------------------------------------
// fqrv_seq
// command sequencer: entry count, key scan with one comparator, gap closing
// ----------------------------------------------------------------------------
module fqrv_seq #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [fqrv_pkg::CMD_W-1:0]   in_command,
  input  logic [fqrv_pkg::VAL_W-1:0]   in_value,
  output fqrv_pkg::seq_status_t        stat,
  output logic                         mem_we,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr,
  output logic [VALUE_BITS-1:0]        mem_wdata,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr,
  input  logic [VALUE_BITS-1:0]        mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic                  deq_r, deq_nxt;
  logic [VALUE_BITS-1:0] hold_r, hold_nxt;

  logic [CW-1:0]         idx_next;
  logic                  more;
  logic                  hit;
  logic                  done;
  logic [fqrv_pkg::STAT_W-1:0] res_status;
  logic [VALUE_BITS-1:0]       res_val;

  // position after the one whose data is in the read register
  assign idx_next = CW'(idx_r) + CW'(1);
  assign more     = (idx_next < count_r);
  assign hit      = deq_r || (mem_rdata == key_r);

  // read one entry ahead of the one being examined
  always_comb begin
    if (state_r == S_IDLE) begin
      mem_raddr = '0;
    end else if (more) begin
      mem_raddr = idx_next[AW-1:0];
    end else begin
      mem_raddr = idx_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    key_nxt    = key_r;
    deq_nxt    = deq_r;
    hold_nxt   = hold_r;
    done       = 1'b0;
    res_status = fqrv_pkg::STAT_OK;
    res_val    = '0;
    mem_we     = 1'b0;
    mem_waddr  = count_r[AW-1:0];
    mem_wdata  = VALUE_BITS'(in_value);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_command)
            fqrv_pkg::CMD_ENQUEUE: begin
              done = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                res_status = fqrv_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            fqrv_pkg::CMD_DEQUEUE, fqrv_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                done       = 1'b1;
                res_status = fqrv_pkg::STAT_MISS;
              end else begin
                state_nxt = S_SCAN;
                idx_nxt   = '0;
                key_nxt   = VALUE_BITS'(in_value);
                deq_nxt   = (in_command == fqrv_pkg::CMD_DEQUEUE);
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      // compare one entry per cycle against the key; a dequeue takes the first entry
      S_SCAN: begin
        if (hit) begin
          hold_nxt = mem_rdata;
          if (more) begin
            state_nxt = S_SHIFT;
            idx_nxt   = idx_next[AW-1:0];
          end else begin
            state_nxt = S_IDLE;
            count_nxt = count_r - CW'(1);
            done      = 1'b1;
            res_val   = mem_rdata;
          end
        end else if (more) begin
          idx_nxt = idx_next[AW-1:0];
        end else begin
          state_nxt  = S_IDLE;
          done       = 1'b1;
          res_status = fqrv_pkg::STAT_MISS;
        end
      end
      // move each later entry down by one place
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - AW'(1);
        mem_wdata = mem_rdata;
        if (more) begin
          idx_nxt = idx_next[AW-1:0];
        end else begin
          state_nxt = S_IDLE;
          count_nxt = count_r - CW'(1);
          done      = 1'b1;
          res_val   = hold_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    deq_r  <= deq_nxt;
    hold_r <= hold_nxt;
  end

  // status toward the top level
  assign stat.idle                  = (state_r == S_IDLE);
  assign stat.done                  = done;
  assign stat.res.status            = res_status;
  assign stat.res.result_value      = fqrv_pkg::VAL_W'(res_val);
  assign stat.res.occupancy         = fqrv_pkg::OCC_W'(count_nxt);

endmodule

### rtl/fifo_queue_with_remove_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value
// bounded queue of handles with dequeue, remove-by-key and size report
// ----------------------------------------------------------------------------
// Commands arrive on in_ch (valid/ready, fields command and value); one
// result per command leaves on out_ch (status, result_value, occupancy).
// Enqueue, size report, and dequeue or remove on an empty queue answer
// without a scan: the result is valid the cycle after the command transfer.
// Dequeue and remove walk the entries through the single memory read port,
// one entry per cycle: the scan runs to the matching entry, then the entries
// behind it move down one place each cycle; the result is valid the cycle
// after the scan or the last move ends.
// in_ch.ready is high while no command is in progress and the result
// register is empty or being drained in the same cycle; a stalled result
// holds on out_ch and blocks further commands.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_value #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  fqrv_in_if.sink     in_ch,
  fqrv_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);

  fqrv_pkg::seq_status_t stat;
  fqrv_pkg::result_t     out_res_r, out_res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  in_fire;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  // accept a command only when the result slot is free by the next edge
  assign in_ch.ready = stat.idle && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  fqrv_seq #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_command (in_ch.command),
    .in_value   (in_ch.value),
    .stat       (stat),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  fqrv_store #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = stat.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.result_value = out_res_r.result_value;
  assign out_ch.occupancy    = out_res_r.occupancy;

endmodule

### rtl/fqrv_checker.sv
// ----------------------------------------------------------------------------
// fqrv_checker
// port-level checks of the queue block, bound to the top level
// ----------------------------------------------------------------------------
`include "fifo_queue_with_remove_by_value_macros.svh"

module fqrv_checker #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [fqrv_pkg::STAT_W-1:0] status,
  input  logic [fqrv_pkg::VAL_W-1:0]  result_value,
  input  logic [fqrv_pkg::OCC_W-1:0]  occupancy
);

  localparam logic [fqrv_pkg::OCC_W-1:0] FULL_OCC = fqrv_pkg::OCC_W'(DEPTH);

  // a stalled result keeps its payload
  `FQRV_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(result_value) && $stable(occupancy)), "stalled result changed")

  // a new command only when the result slot drains
  `FQRV_ASSERT(a_slot_free, (in_valid && in_ready) |-> (!out_valid || out_ready), "command taken while result pending")

  // failed commands return no handle, full means full
  `FQRV_ASSERT(a_err_zero, (out_valid && status != fqrv_pkg::STAT_OK) |-> (result_value == '0 && (status != fqrv_pkg::STAT_FULL || occupancy == FULL_OCC)), "bad error result")

  // reset drops any pending result
  `FQRV_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fifo_queue_with_remove_by_value fqrv_checker #(
  .DEPTH (DEPTH)
) u_fqrv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .result_value (out_ch.result_value),
  .occupancy    (out_ch.occupancy)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the handle queue with remove-by-key
// ----------------------------------------------------------------------------
// A directed opening covers the empty and full queue, handles 0 and 1023,
// duplicate handles, a miss on remove and the size report. Random traffic
// follows in segments whose enqueue share varies, so the queue swings
// between empty and full. Keys come mostly from a small set of handles, so
// removes often hit. A shadow queue predicts every result. The monitor
// compares each result transfer field by field with the oldest prediction.
// Both channels idle at random, except in one quiet window.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int VALUE_BITS  = 10;
  localparam int RANDOM_CMDS = 1100;
  localparam int SEGMENT_LEN = 40;
  localparam int IDLE_PCT    = 35;
  localparam int QUIET_FROM  = 800;
  localparam int QUIET_TO    = 2000;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

  typedef struct packed {
    logic [fqrv_pkg::CMD_W-1:0] cmd;
    logic [fqrv_pkg::VAL_W-1:0] val;
  } cmd_item_t;

  logic clk;
  logic rst_n;

  fqrv_in_if  in_ch ();
  fqrv_out_if out_ch ();

  fifo_queue_with_remove_by_value #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cmd_item_t                  pending_cmds[$];
  fqrv_pkg::result_t          expected_results[$];
  logic [fqrv_pkg::VAL_W-1:0] shadow_queue[$];
  int                         error_count = 0;
  int                         cycle_count = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // random idle decision, none inside the quiet window
  function automatic bit take_idle();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // shadow of the queue: apply one command, return the result it causes
  function automatic fqrv_pkg::result_t queue_step(logic [fqrv_pkg::CMD_W-1:0] cmd,
                                                   logic [fqrv_pkg::VAL_W-1:0] val);
    fqrv_pkg::result_t res;
    int                hit;
    res.status       = fqrv_pkg::STAT_OK;
    res.result_value = '0;
    hit              = -1;
    case (cmd)
      fqrv_pkg::CMD_ENQUEUE: begin
        if (shadow_queue.size() >= DEPTH) begin
          res.status = fqrv_pkg::STAT_FULL;
        end else begin
          shadow_queue.push_back(val);
        end
      end
      fqrv_pkg::CMD_DEQUEUE: begin
        if (shadow_queue.size() == 0) begin
          res.status = fqrv_pkg::STAT_MISS;
        end else begin
          res.result_value = shadow_queue.pop_front();
        end
      end
      fqrv_pkg::CMD_REMOVE: begin
        // first match from the head only
        foreach (shadow_queue[i]) begin
          if (hit < 0 && shadow_queue[i] == val) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          res.status = fqrv_pkg::STAT_MISS;
        end else begin
          res.result_value = shadow_queue[hit];
          shadow_queue.delete(hit);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = fqrv_pkg::OCC_W'(shadow_queue.size());
    return res;
  endfunction

  task automatic add_cmd(logic [fqrv_pkg::CMD_W-1:0] cmd, logic [fqrv_pkg::VAL_W-1:0] val);
    cmd_item_t item;
    item.cmd = cmd;
    item.val = val;
    pending_cmds.push_back(item);
  endtask

  // mostly a small set of handles so removes hit, with extremes and full range
  function automatic logic [fqrv_pkg::VAL_W-1:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return fqrv_pkg::VAL_W'($urandom_range(0, 7));
    end else if (roll < 65) begin
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    return fqrv_pkg::VAL_W'($urandom_range(0, (1 << fqrv_pkg::VAL_W) - 1));
  endfunction

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= fqrv_pkg::CMD_SIZE;
      in_ch.value   <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(queue_step(in_ch.command, in_ch.value));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && !take_idle()) begin
          in_ch.valid   <= 1'b1;
          in_ch.command <= pending_cmds[0].cmd;
          in_ch.value   <= pending_cmds[0].val;
          void'(pending_cmds.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d value %0d occ %0d",
                   $time, out_ch.status, out_ch.result_value, out_ch.occupancy);
          error_count++;
        end else begin
          report_field("status", 32'(expected_results[0].status), 32'(out_ch.status));
          report_field("result_value", 32'(expected_results[0].result_value),
                       32'(out_ch.result_value));
          report_field("occupancy", 32'(expected_results[0].occupancy),
                       32'(out_ch.occupancy));
          void'(expected_results.pop_front());
        end
      end
      out_ch.ready <= !take_idle();
    end
  end

  // stimulus, reset and end of run
  initial begin
    int enq_pct;
    int roll;
    rst_n = 1'b0;

    // empty queue cases
    add_cmd(fqrv_pkg::CMD_SIZE, '0);
    add_cmd(fqrv_pkg::CMD_DEQUEUE, '0);
    add_cmd(fqrv_pkg::CMD_REMOVE, 10'd5);
    // extremes and a duplicate, then fill to full
    add_cmd(fqrv_pkg::CMD_ENQUEUE, '0);
    add_cmd(fqrv_pkg::CMD_ENQUEUE, '1);
    add_cmd(fqrv_pkg::CMD_ENQUEUE, 10'd7);
    add_cmd(fqrv_pkg::CMD_ENQUEUE, 10'd7);
    for (int i = 0; i < DEPTH - 4; i++) begin
      add_cmd(fqrv_pkg::CMD_ENQUEUE, 10'(100 + 3 * i));
    end
    add_cmd(fqrv_pkg::CMD_ENQUEUE, 10'd5);
    add_cmd(fqrv_pkg::CMD_SIZE, '0);
    // duplicate removes the one nearest the head, handle 0 matches, a miss
    add_cmd(fqrv_pkg::CMD_REMOVE, 10'd7);
    add_cmd(fqrv_pkg::CMD_REMOVE, '0);
    add_cmd(fqrv_pkg::CMD_REMOVE, 10'd999);
    add_cmd(fqrv_pkg::CMD_DEQUEUE, '0);
    add_cmd(fqrv_pkg::CMD_REMOVE, 10'd7);

    // random segments with a varying enqueue share
    enq_pct = 50;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
        add_cmd(fqrv_pkg::CMD_ENQUEUE, pick_handle());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          add_cmd(fqrv_pkg::CMD_DEQUEUE,
                  fqrv_pkg::VAL_W'($urandom_range(0, (1 << fqrv_pkg::VAL_W) - 1)));
        end else if (roll < 85) begin
          add_cmd(fqrv_pkg::CMD_REMOVE, pick_handle());
        end else begin
          add_cmd(fqrv_pkg::CMD_SIZE,
                  fqrv_pkg::VAL_W'($urandom_range(0, (1 << fqrv_pkg::VAL_W) - 1)));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all transfers and results, then watch for stray results
    while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("fifo_queue_with_remove_by_value regression: pass");
    end else begin
      $display("fifo_queue_with_remove_by_value regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("fifo_queue_with_remove_by_value regression: fail");
    $finish;
  end

endmodule
